[hw/rtl/s2l16_pkg.sv]
`timescale 1ns / 1ps
// s2l16_pkg: widths, constant tables and latency of the log16 sample encoder
// used by sample_to_log16_encoder and its checker; depends on nothing else

package s2l16_pkg;

    localparam int FRAC_BITS = 8;

    localparam int SAMPLE_W = 33;
    localparam int MAG_W    = 33;
    localparam int LOW_W    = 8;
    localparam int HIGH_W   = 7;

    localparam int EXP_MAX  = 47;
    localparam int EXP_W    = 6;
    localparam int NEG_BASE = 96;

    localparam int LOW_MUL  = 712;
    localparam int LOW_SUB  = 615;
    localparam int LOW_MAX  = 255;
    localparam int LOW_TOP  = LOW_SUB + LOW_MAX + 1;

    // 712 * 2^32 stays below 2^42
    localparam int PROD_W   = 42;
    localparam int QUO_IN_W = PROD_W - FRAC_BITS;
    localparam int CMP_W    = PROD_W;

    localparam int TH_W     = 40;
    localparam int STEP_W   = 24;
    localparam int REM_W    = STEP_W + LOW_W;

    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = LOW_W / DIV_STAGES;

    // magnitude, compare, encode, bounds, divider stages, output register
    localparam int PIPE_LAT = 5 + DIV_STAGES;

    localparam logic [63:0] ODD_Q40  = 64'd952547447087;
    localparam logic [63:0] EVEN_Q40 = 64'd673552759258;
    localparam int          Q_SHIFT  = 40;

    typedef logic [STEP_W-1:0] t_step_tab [0:EXP_MAX];
    typedef logic [CMP_W-1:0]  t_bnd_tab  [0:EXP_MAX];
    typedef logic [TH_W-1:0]   t_th_tab   [0:EXP_MAX-1];

    localparam t_step_tab STEP_REF = '{
        24'd1,       24'd1,       24'd1,       24'd2,       24'd3,       24'd4,
        24'd6,       24'd8,       24'd11,      24'd16,      24'd23,      24'd32,
        24'd45,      24'd64,      24'd91,      24'd128,     24'd181,     24'd256,
        24'd362,     24'd512,     24'd724,     24'd1024,    24'd1448,    24'd2048,
        24'd2896,    24'd4096,    24'd5793,    24'd8192,    24'd11585,   24'd16384,
        24'd23170,   24'd32768,   24'd46341,   24'd65536,   24'd92682,   24'd131072,
        24'd185364,  24'd262144,  24'd370728,  24'd524288,  24'd741455,  24'd1048576,
        24'd1482910, 24'd2097152, 24'd2965821, 24'd4194304, 24'd5931642, 24'd8388608
    };

    // integer magnitude at which exponent h is reached, rounded up
    function automatic t_th_tab f_th_tab();
        t_th_tab     tab;
        int          j;
        int          sh;
        logic [63:0] q;
        logic [63:0] t;
        for (int h = 1; h <= EXP_MAX; h++) begin
            j  = h >>> 1;
            q  = (h % 2 == 1) ? ODD_Q40 : EVEN_Q40;
            sh = Q_SHIFT - j - FRAC_BITS;
            t  = (q + ((64'd1 << sh) - 64'd1)) >> sh;
            tab[h-1] = t[TH_W-1:0];
        end
        return tab;
    endfunction

    function automatic t_bnd_tab f_bnd_tab(input int mul);
        t_bnd_tab tab;
        for (int h = 0; h <= EXP_MAX; h++) begin
            tab[h] = CMP_W'(STEP_REF[h]) * CMP_W'(mul);
        end
        return tab;
    endfunction

    localparam t_th_tab  THRESH = f_th_tab();
    localparam t_bnd_tab LO_BND = f_bnd_tab(LOW_SUB);
    localparam t_bnd_tab HI_BND = f_bnd_tab(LOW_TOP);

endpackage

[hw/rtl/sample_to_log16_encoder.sv]
`timescale 1ns / 1ps
// sample_to_log16_encoder: signed fixed-point sample to two-byte log code
// depends on s2l16_pkg

// One sample is taken on every clock edge where start is high (busy is
// always low, so the block never holds a sample off), and its code appears
// on o_code_low / o_code_high with o_strobe high for one cycle. Codes come
// out in the order samples went in. The pipeline stages are: magnitude, 47
// parallel threshold compares, exponent encode, mantissa bounds, four
// radix-2 divider stages of two quotient bits each, and the output
// register. The receiver cannot stall, so results must be captured when
// o_strobe is high.

module sample_to_log16_encoder (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    input  logic signed [s2l16_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                   busy,
    output logic                                   o_strobe,
    output logic        [s2l16_pkg::LOW_W-1:0]     o_code_low,
    output logic        [s2l16_pkg::HIGH_W-1:0]    o_code_high
);
    import s2l16_pkg::*;

    logic [MAG_W-1:0]     w_samp_u;
    logic [MAG_W-1:0]     n_s1_mag;

    logic                 r_s1_valid;
    logic [MAG_W-1:0]     r_s1_mag;
    logic                 r_s1_neg;

    logic [EXP_MAX-1:0]   n_s2_therm;
    logic [PROD_W-1:0]    w_prod;
    logic                 r_s2_valid;
    logic [EXP_MAX-1:0]   r_s2_therm;
    logic [QUO_IN_W-1:0]  r_s2_quo_in;
    logic                 r_s2_small;
    logic                 r_s2_neg;

    logic [EXP_W-1:0]     n_s3_h;
    logic                 r_s3_valid;
    logic [EXP_W-1:0]     r_s3_h;
    logic [QUO_IN_W-1:0]  r_s3_quo_in;
    logic                 r_s3_small;
    logic                 r_s3_neg;

    logic [CMP_W-1:0]     w_num;
    logic [CMP_W-1:0]     w_diff;
    logic [HIGH_W-1:0]    n_high;

    logic                 r_dv_valid [0:DIV_STAGES];
    logic [REM_W-1:0]     r_dv_rem   [0:DIV_STAGES];
    logic [LOW_W-1:0]     r_dv_quo   [0:DIV_STAGES];
    logic [STEP_W-1:0]    r_dv_div   [0:DIV_STAGES];
    logic                 r_dv_sat   [0:DIV_STAGES];
    logic                 r_dv_zero  [0:DIV_STAGES];
    logic [HIGH_W-1:0]    r_dv_high  [0:DIV_STAGES];
    logic [REM_W-1:0]     n_dv_rem   [0:DIV_STAGES-1];
    logic [LOW_W-1:0]     n_dv_quo   [0:DIV_STAGES-1];

    logic [LOW_W-1:0]     n_low;
    logic                 r_o_valid;
    logic [LOW_W-1:0]     r_o_low;
    logic [HIGH_W-1:0]    r_o_high;

    // stage 1: magnitude, -2^32 wraps to 2^32 as an unsigned value
    assign w_samp_u = i_sample;
    assign n_s1_mag = w_samp_u[MAG_W-1] ? (~w_samp_u + MAG_W'(1)) : w_samp_u;

    // stage 2: thermometer of thresholds reached, scaled product for mantissa
    always_comb begin
        for (int k = 0; k < EXP_MAX; k++) begin
            n_s2_therm[k] = (TH_W'(r_s1_mag) >= THRESH[k]);
        end
    end
    assign w_prod = PROD_W'(r_s1_mag) * PROD_W'(LOW_MUL);

    // stage 3: thresholds rise with h, so the highest one reached is the exponent
    always_comb begin
        n_s3_h = '0;
        for (int k = 0; k < EXP_MAX; k++) begin
            if (r_s2_therm[k]) begin
                n_s3_h = EXP_W'(k + 1);
            end
        end
    end

    // stage 4: only quotients 615..870 matter, so clip against both bounds
    assign w_num  = CMP_W'(r_s3_quo_in);
    assign w_diff = w_num - LO_BND[r_s3_h];

    always_comb begin
        if (r_s3_small) begin
            n_high = '0;
        end else if (r_s3_neg && (r_s3_h != '0)) begin
            n_high = HIGH_W'(NEG_BASE) - HIGH_W'(r_s3_h);
        end else begin
            n_high = HIGH_W'(r_s3_h);
        end
    end

    // divider stages: restoring division of the offset remainder by r[h]
    always_comb begin
        logic [REM_W-1:0] rem;
        logic [LOW_W-1:0] quo;
        logic [REM_W-1:0] trial;
        for (int d = 0; d < DIV_STAGES; d++) begin
            rem = r_dv_rem[d];
            quo = r_dv_quo[d];
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                trial = REM_W'(r_dv_div[d]) << (LOW_W - 1 - d * BITS_PER_STAGE - b);
                if (rem >= trial) begin
                    rem = rem - trial;
                    quo[LOW_W - 1 - d * BITS_PER_STAGE - b] = 1'b1;
                end
            end
            n_dv_rem[d] = rem;
            n_dv_quo[d] = quo;
        end
    end

    always_comb begin
        if (r_dv_zero[DIV_STAGES]) begin
            n_low = '0;
        end else if (r_dv_sat[DIV_STAGES]) begin
            n_low = LOW_W'(LOW_MAX);
        end else begin
            n_low = r_dv_quo[DIV_STAGES];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            for (int d = 0; d <= DIV_STAGES; d++) begin
                r_dv_valid[d] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else begin
            r_s1_valid    <= start && !busy;
            r_s2_valid    <= r_s1_valid;
            r_s3_valid    <= r_s2_valid;
            r_dv_valid[0] <= r_s3_valid;
            for (int d = 0; d < DIV_STAGES; d++) begin
                r_dv_valid[d+1] <= r_dv_valid[d];
            end
            r_o_valid <= r_dv_valid[DIV_STAGES];
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_s1_mag <= n_s1_mag;
        r_s1_neg <= i_sample[SAMPLE_W-1];

        r_s2_therm  <= n_s2_therm;
        r_s2_quo_in <= w_prod[PROD_W-1:FRAC_BITS];
        r_s2_small  <= (r_s1_mag < (MAG_W'(1) << (FRAC_BITS - 1)));
        r_s2_neg    <= r_s1_neg;

        r_s3_h      <= n_s3_h;
        r_s3_quo_in <= r_s2_quo_in;
        r_s3_small  <= r_s2_small;
        r_s3_neg    <= r_s2_neg;

        r_dv_rem[0]  <= w_diff[REM_W-1:0];
        r_dv_quo[0]  <= '0;
        r_dv_div[0]  <= STEP_REF[r_s3_h];
        r_dv_sat[0]  <= (w_num >= HI_BND[r_s3_h]);
        r_dv_zero[0] <= r_s3_small || (w_num < LO_BND[r_s3_h]);
        r_dv_high[0] <= n_high;

        for (int d = 0; d < DIV_STAGES; d++) begin
            r_dv_rem[d+1]  <= n_dv_rem[d];
            r_dv_quo[d+1]  <= n_dv_quo[d];
            r_dv_div[d+1]  <= r_dv_div[d];
            r_dv_sat[d+1]  <= r_dv_sat[d];
            r_dv_zero[d+1] <= r_dv_zero[d];
            r_dv_high[d+1] <= r_dv_high[d];
        end

        r_o_low  <= n_low;
        r_o_high <= r_dv_high[DIV_STAGES];
    end

    assign busy        = 1'b0;
    assign o_strobe    = r_o_valid;
    assign o_code_low  = r_o_low;
    assign o_code_high = r_o_high;

endmodule

[hw/rtl/s2l16_checker.sv]
`timescale 1ns / 1ps
// s2l16_checker: port-level checks of sample_to_log16_encoder, bound to it below
// depends on s2l16_pkg

module s2l16_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic signed [s2l16_pkg::SAMPLE_W-1:0]  i_sample,
    input logic                                   busy,
    input logic                                   o_strobe,
    input logic        [s2l16_pkg::LOW_W-1:0]     o_code_low,
    input logic        [s2l16_pkg::HIGH_W-1:0]    o_code_high
);
    import s2l16_pkg::*;

    // every transfer in gives one code out after the fixed latency
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_strobe)
        else $error("missing strobe after accepted sample");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, PIPE_LAT))
        else $error("strobe without a matching sample");

    a_high_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_code_high <= HIGH_W'(EXP_MAX)
                      || (o_code_high >= HIGH_W'(NEG_BASE - EXP_MAX)
                          && o_code_high <= HIGH_W'(NEG_BASE - 1))))
        else $error("exponent byte out of range");

    a_zero_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_sample == '0) |->
            ##PIPE_LAT (o_code_low == '0 && o_code_high == '0))
        else $error("zero sample did not give a zero code");

endmodule

bind sample_to_log16_encoder s2l16_checker u_s2l16_checker (.*);
